FILE: rtl/core/pcsc_pkg.sv
// Package for the PNG chunk stream checker.
// Holds beat types, phase and code constants, the signature table and the CRC-32 step.
// No dependencies.
`default_nettype none
package pcsc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] chunk_type;
        logic [2:0]  chunk_kind;
        logic [31:0] chunk_length;
        logic        crc_ok;
        logic [1:0]  status;
        logic [7:0]  kept_color;
    } out_beat_t;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC
    } phase_t;

    localparam logic [2:0] KIND_IHDR  = 3'd0;
    localparam logic [2:0] KIND_BKGD  = 3'd1;
    localparam logic [2:0] KIND_PHYS  = 3'd2;
    localparam logic [2:0] KIND_TIME  = 3'd3;
    localparam logic [2:0] KIND_OTHER = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_SIG = 2'd1;
    localparam logic [1:0] STAT_BAD_LEN = 2'd2;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_BKGD = 32'h624B_4744;
    localparam logic [31:0] TYPE_PHYS = 32'h7048_5973;
    localparam logic [31:0] TYPE_TIME = 32'h7449_4D45;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

    localparam logic [31:0] IHDR_COLOR_IDX = 32'd9;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0: r = 8'h89;
            3'd1: r = 8'h50;
            3'd2: r = 8'h4E;
            3'd3: r = 8'h47;
            3'd4: r = 8'h0D;
            3'd5: r = 8'h0A;
            3'd6: r = 8'h1A;
            3'd7: r = 8'h0A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [2:0] kind_of(input logic [31:0] t);
        logic [2:0] r;
        priority if (t == TYPE_IHDR) r = KIND_IHDR;
        else if (t == TYPE_BKGD) r = KIND_BKGD;
        else if (t == TYPE_PHYS) r = KIND_PHYS;
        else if (t == TYPE_TIME) r = KIND_TIME;
        else r = KIND_OTHER;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pcsc_front.sv
// Front end of the PNG chunk stream checker: signature check, chunk walk and CRC-32.
// Emits one result beat per finished chunk or error. Depends on pcsc_pkg.
`default_nettype none
module pcsc_front
    import pcsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      take,
    input  wire in_beat_t  beat,
    output logic           emit,
    output out_beat_t      result
);

    phase_t      phase_reg, phase_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic [7:0]  color_reg, color_next;
    logic [2:0]  kind_reg, kind_next;
    logic        halt_reg, halt_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_SIG;
            cnt_reg   <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            crc_reg   <= CRC_PRESET;
            rcrc_reg  <= '0;
            color_reg <= '0;
            kind_reg  <= KIND_OTHER;
            halt_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
            color_reg <= color_next;
            kind_reg  <= kind_next;
            halt_reg  <= halt_next;
        end
    end

    always_comb begin
        logic [7:0]  b;
        logic [31:0] new_type;
        logic [31:0] new_rcrc;
        logic [2:0]  k;
        logic        bad;

        b        = beat.data_byte;
        new_type = '0;
        new_rcrc = '0;
        k        = KIND_OTHER;
        bad      = 1'b0;

        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        color_next = color_reg;
        kind_next  = kind_reg;
        halt_next  = halt_reg;
        emit       = 1'b0;
        result     = '{chunk_type: '0, chunk_kind: KIND_OTHER, chunk_length: '0,
                       crc_ok: 1'b0, status: STAT_OK, kept_color: color_reg};

        if (take && beat.file_start) begin
            phase_next = PH_SIG;
            cnt_next   = '0;
            len_next   = '0;
            type_next  = '0;
            crc_next   = CRC_PRESET;
            rcrc_next  = '0;
            color_next = '0;
            halt_next  = 1'b0;
            result.kept_color = 8'd0;
        end

        if (take && (beat.file_start || !halt_reg)) begin
            unique case (phase_next)
                PH_SIG: begin
                    if (b != sig_byte(cnt_next[2:0])) begin
                        halt_next = 1'b1;
                        emit      = 1'b1;
                        result.status = STAT_BAD_SIG;
                    end else if (cnt_next == 32'd7) begin
                        phase_next = PH_LEN;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_next + 32'd1;
                    end
                end
                PH_LEN: begin
                    len_next = {len_next[23:0], b};
                    if (cnt_next == 32'd3) begin
                        phase_next = PH_TYPE;
                        cnt_next   = '0;
                        crc_next   = CRC_PRESET;
                    end else begin
                        cnt_next = cnt_next + 32'd1;
                    end
                end
                PH_TYPE: begin
                    new_type  = {type_next[23:0], b};
                    type_next = new_type;
                    crc_next  = crc_step(crc_next, b);
                    if (cnt_next == 32'd3) begin
                        cnt_next  = '0;
                        k         = kind_of(new_type);
                        kind_next = k;
                        unique case (k)
                            KIND_IHDR: bad = (len_next != 32'd13);
                            KIND_PHYS: bad = (len_next != 32'd9);
                            KIND_TIME: bad = (len_next != 32'd7);
                            KIND_BKGD: begin
                                unique case (color_next)
                                    8'd3:       bad = (len_next != 32'd1);
                                    8'd0, 8'd4: bad = (len_next != 32'd2);
                                    8'd2, 8'd6: bad = (len_next != 32'd6);
                                    default:    bad = 1'b0;
                                endcase
                            end
                            default: bad = 1'b0;
                        endcase
                        if (bad) begin
                            halt_next = 1'b1;
                            emit      = 1'b1;
                            result.chunk_type   = new_type;
                            result.chunk_kind   = k;
                            result.chunk_length = len_next;
                            result.status       = STAT_BAD_LEN;
                        end else begin
                            phase_next = (len_next == '0) ? PH_CRC : PH_DATA;
                        end
                    end else begin
                        cnt_next = cnt_next + 32'd1;
                    end
                end
                PH_DATA: begin
                    crc_next = crc_step(crc_next, b);
                    if (cnt_next == IHDR_COLOR_IDX && kind_next == KIND_IHDR) begin
                        color_next = b;
                    end
                    if (cnt_next + 32'd1 == len_next) begin
                        phase_next = PH_CRC;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_next + 32'd1;
                    end
                end
                PH_CRC: begin
                    new_rcrc  = {rcrc_next[23:0], b};
                    rcrc_next = new_rcrc;
                    if (cnt_next == 32'd3) begin
                        emit = 1'b1;
                        result.chunk_type   = type_next;
                        result.chunk_kind   = kind_next;
                        result.chunk_length = len_next;
                        result.crc_ok       = (new_rcrc == ~crc_next);
                        result.status       = STAT_OK;
                        result.kept_color   = color_next;
                        phase_next = PH_LEN;
                        cnt_next   = '0;
                        len_next   = '0;
                    end else begin
                        cnt_next = cnt_next + 32'd1;
                    end
                end
                default: begin
                    phase_next = PH_LEN;
                    cnt_next   = '0;
                    len_next   = '0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/pcsc_queue.sv
// Two-entry result queue of the PNG chunk stream checker; the output is read from the queue entries.
// Decouples the parser from the result channel. Depends on pcsc_pkg.
`default_nettype none
module pcsc_queue
    import pcsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_beat_t push_beat,
    output logic           full,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_beat_t      result
);

    out_beat_t   mem_reg [2];
    logic        wr_reg, rd_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign pop          = result_valid && !result_stall;
    assign full         = (count_reg == 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign result       = mem_reg[rd_reg];

    always_comb begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/png_chunk_stream_checker_top.sv
// Top level of the PNG chunk stream checker: one byte beat per cycle in while not stalled,
// one result beat per finished chunk or error out. The result beat is registered in the
// result queue. Throughput is one byte per cycle while not stalled, set by the combinational
// CRC-32 byte update. The input stalls only while the two-entry result queue is full.
// Asynchronous active-low reset puts the parser in the signature phase with an empty queue.
`default_nettype none
module png_chunk_stream_checker_top
    import pcsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire in_beat_t  item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_beat_t      result
);

    logic      take;
    logic      emit;
    logic      full;
    out_beat_t front_beat;

    assign item_stall = full;
    assign take       = item_valid && !full;

    pcsc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .beat   (item),
        .emit   (emit),
        .result (front_beat)
    );

    pcsc_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (emit),
        .push_beat    (front_beat),
        .full         (full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

FILE: rtl/core/pcsc_checker.sv
// Port-level checks for the PNG chunk stream checker, bound to the top level.
// Depends on pcsc_pkg.
`default_nettype none
module pcsc_checker
    import pcsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_stall,
    input  wire logic      result_valid,
    input  wire logic      result_stall,
    input  wire out_beat_t result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_err_crc: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != STAT_OK |-> !result.crc_ok)
        else $error("error beat claims a good CRC");

    a_sig: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STAT_BAD_SIG |->
        result.chunk_type == '0 && result.chunk_length == '0
        && result.chunk_kind == KIND_OTHER)
        else $error("bad signature beat carries chunk data");

    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status <= STAT_BAD_LEN && result.chunk_kind <= KIND_OTHER)
        else $error("result beat with undefined code");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> $past(result_valid))
        else $error("input stalled with no pending result");

endmodule

bind png_chunk_stream_checker_top pcsc_checker u_pcsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire
